/* design/sst_rc_pkg.sv */
// Shared widths, register codes and reset values for the SST rotation-corrected
// TKE source block. No dependencies; used by every other file of the block.
package sst_rc_pkg;

  // scalar and gradient field widths
  localparam int SCAL_W = 32;
  localparam int GRAD_W = 21;
  localparam int ROW_W  = 63;
  localparam int CFG_W  = 16;
  localparam int OUT_W  = 48;

  // stream bus widths
  localparam int IN_TDATA_W  = 352;
  localparam int OUT_TDATA_W = 96;

  // strain sum, divider denominator, remainder and quotient widths
  localparam int SQ_W  = 46;
  localparam int DEN_W = 47;
  localparam int REM_W = 48;
  localparam int Q_W   = 17;

  // payload carried alongside the divider: five scalars and the strain sum
  localparam int PAY_W = 5 * SCAL_W + SQ_W;

  localparam int MAX_DIMS_DEF = 3;

  // configuration register indexes
  localparam logic [1:0] REG_BETA  = 2'd0;
  localparam logic [1:0] REG_RATIO = 2'd1;
  localparam logic [1:0] REG_CR1   = 2'd2;
  localparam logic [1:0] REG_DIMS  = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] RST_BETA  = 16'd5898;
  localparam logic [CFG_W-1:0] RST_RATIO = 16'd2560;
  localparam logic [CFG_W-1:0] RST_CR1   = 16'd256;
  localparam logic [1:0]       RST_DIMS  = 2'd3;
  localparam logic [1:0]       DIMS_2D   = 2'd2;

  // saturation limits
  localparam logic [61:0] LIM62  = {62{1'b1}};
  localparam logic [47:0] MAX48U = {48{1'b1}};
  localparam logic [47:0] POS47  = {1'b0, {47{1'b1}}};
  localparam logic [47:0] NEG47  = {1'b1, {47{1'b0}}};
  localparam logic [24:0] F_MAX  = 25'd20971520;

endpackage

/* design/sst_rc_div.sv */
// Pipelined restoring divider for the rotation ratio q = floor(2*sf*2^16/(sf+wf)).
// One quotient bit per stage; carries a side payload. Depends on sst_rc_pkg.
module sst_rc_div #(
  parameter int PW = sst_rc_pkg::PAY_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [sst_rc_pkg::SQ_W-1:0]   sf,
  input  logic [sst_rc_pkg::SQ_W-1:0]   wf,
  input  logic [PW-1:0]                 pay_in,
  output logic                          out_valid,
  output logic [sst_rc_pkg::Q_W-1:0]    q,
  output logic [PW-1:0]                 pay_out
);

  localparam int NSTEP = sst_rc_pkg::Q_W;
  localparam int RW    = sst_rc_pkg::REM_W;
  localparam int DW    = sst_rc_pkg::DEN_W;
  localparam int QW    = sst_rc_pkg::Q_W;

  logic [RW-1:0] rem_r [0:NSTEP];
  logic [DW-1:0] den_r [0:NSTEP];
  logic [QW-1:0] q_r   [0:NSTEP];
  logic [PW-1:0] pay_r [0:NSTEP];
  logic [NSTEP:0] v_r;

  // advance valid bits with the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTEP-1:0], in_valid};
    end
  end

  // setup stage: denominator and doubled numerator
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= DW'(sf) + DW'(wf);
      rem_r[0] <= {1'b0, sf, 1'b0};
      q_r[0]   <= '0;
      pay_r[0] <= pay_in;
    end
  end

  // one compare-and-subtract per stage; the first step has no shift
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [RW-1:0] r;
    logic          ge;
    if (k == 1) begin : g_first
      assign r = rem_r[k-1];
    end else begin : g_rest
      assign r = {rem_r[k-1][RW-2:0], 1'b0};
    end
    assign ge = (r >= RW'(den_r[k-1]));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (r - RW'(den_r[k-1])) : r;
        q_r[k]   <= {q_r[k-1][QW-2:0], ge};
        den_r[k] <= den_r[k-1];
        pay_r[k] <= pay_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NSTEP];
  assign q         = q_r[NSTEP];
  assign pay_out   = pay_r[NSTEP];

endmodule

/* design/sst_tke_source_rotation_correction.sv */
// Top level of the SST rotation-corrected TKE source term pipeline.
// Depends on sst_rc_pkg and sst_rc_div.
//
// Usage:
//   One mesh node enters per transfer on the s_ group (kinetic energy,
//   dissipation rate, density, eddy viscosity, volume and three gradient
//   rows); one result leaves per transfer on the m_ group (RHS increment,
//   diagonal increment). Registers are written through cfg_we/cfg_index/
//   cfg_data while the pipe is empty.
//   Throughput: one node per cycle, back to back, while m_tready does not stall.
//   Pipeline: three front stages (field capture, gradient squares,
//   strain/vorticity sums), 18 divider stages (setup plus one quotient bit
//   each) and 14 stages of split multiplies, saturation and the final
//   signed select.
//   Reset: rst clears all valid bits and loads the register defaults.
//   Stall: when m_tvalid is high and m_tready low, the whole pipe holds and
//   s_tready drops in the same cycle; nothing is lost or repeated. The last
//   stage is the output register.
module sst_tke_source_rotation_correction #(
  parameter int MAX_DIMS = sst_rc_pkg::MAX_DIMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // turb_kinetic_energy, dissipation_rate, fluid_density, eddy_viscosity,
  // cell_volume, grad_row_x, grad_row_y, grad_row_z, zero pad
  input  logic [sst_rc_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // rhs_increment, lhs_increment
  output logic [sst_rc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [sst_rc_pkg::CFG_W-1:0]        cfg_data
);

  localparam int SW  = sst_rc_pkg::SCAL_W;
  localparam int GW  = sst_rc_pkg::GRAD_W;
  localparam int RWD = sst_rc_pkg::ROW_W;
  localparam int QW  = sst_rc_pkg::Q_W;
  localparam int SQW = sst_rc_pkg::SQ_W;
  localparam int PW  = sst_rc_pkg::PAY_W;
  localparam bit HAS_3D = (MAX_DIMS > 2);
  localparam int PA [3] = '{0, 0, 1};
  localparam int PB [3] = '{1, 2, 2};

  // configuration registers
  logic [15:0] beta_star;
  logic [15:0] ratio;
  logic [15:0] cr1;
  logic [1:0]  num_dims;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_star <= sst_rc_pkg::RST_BETA;
      ratio     <= sst_rc_pkg::RST_RATIO;
      cr1       <= sst_rc_pkg::RST_CR1;
      num_dims  <= sst_rc_pkg::RST_DIMS;
    end else if (cfg_we) begin
      case (cfg_index)
        sst_rc_pkg::REG_BETA:  beta_star <= cfg_data;
        sst_rc_pkg::REG_RATIO: ratio     <= cfg_data;
        sst_rc_pkg::REG_CR1:   cr1       <= cfg_data;
        sst_rc_pkg::REG_DIMS:  num_dims  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic use3d;
  assign use3d = HAS_3D && (num_dims != sst_rc_pkg::DIMS_2D);

  // global advance: hold everything while the output transfer is stalled
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- front stage 1: capture fields
  logic          v1;
  logic [SW-1:0] tke1, omg1, rho1, nut1, vol1;
  logic [RWD-1:0] row1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tke1    <= s_tdata[31:0];
      omg1    <= s_tdata[63:32];
      rho1    <= s_tdata[95:64];
      nut1    <= s_tdata[127:96];
      vol1    <= s_tdata[159:128];
      row1[0] <= s_tdata[222:160];
      row1[1] <= s_tdata[285:223];
      row1[2] <= s_tdata[348:286];
    end
  end

  // ---------------- front stage 2: gradient entries and squares
  logic signed [GW-1:0]   g [3][3];
  logic signed [GW:0]     sd [3];
  logic signed [GW:0]     so [3];
  logic signed [GW:0]     wo [3];
  logic signed [2*GW+1:0] psd [3];
  logic signed [2*GW+1:0] pso [3];
  logic signed [2*GW+1:0] pwo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        g[i][j] = row1[i][GW*j +: GW];
        // drop the third row and column in 2-D
        if (!use3d && (i == 2 || j == 2)) begin
          g[i][j] = '0;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      sd[k]  = {g[k][k], 1'b0};
      so[k]  = (GW+1)'(g[PA[k]][PB[k]]) + (GW+1)'(g[PB[k]][PA[k]]);
      wo[k]  = (GW+1)'(g[PA[k]][PB[k]]) - (GW+1)'(g[PB[k]][PA[k]]);
      psd[k] = sd[k] * sd[k];
      pso[k] = so[k] * so[k];
      pwo[k] = wo[k] * wo[k];
    end
  end

  logic            v2;
  logic [SW-1:0]   tke2, omg2, rho2, nut2, vol2;
  logic [2*GW:0]   sqd2 [3];
  logic [2*GW:0]   sqs2 [3];
  logic [2*GW:0]   sqw2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tke2 <= tke1;
      omg2 <= omg1;
      rho2 <= rho1;
      nut2 <= nut1;
      vol2 <= vol1;
      for (int k = 0; k < 3; k++) begin
        sqd2[k] <= psd[k][2*GW:0];
        sqs2[k] <= pso[k][2*GW:0];
        sqw2[k] <= pwo[k][2*GW:0];
      end
    end
  end

  // ---------------- front stage 3: strain and vorticity sums, LSB floor
  logic [SQW-1:0] sp_sum, wp_sum;

  always_comb begin
    sp_sum = SQW'(sqd2[0]) + SQW'(sqd2[1]) + SQW'(sqd2[2])
           + ((SQW'(sqs2[0]) + SQW'(sqs2[1]) + SQW'(sqs2[2])) << 1);
    wp_sum = (SQW'(sqw2[0]) + SQW'(sqw2[1]) + SQW'(sqw2[2])) << 1;
  end

  logic           v3;
  logic [SQW-1:0] sp3, sf3, wf3;
  logic [SW-1:0]  tke3, omg3, rho3, nut3, vol3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp3  <= sp_sum;
      sf3  <= (sp_sum == '0) ? SQW'(1) : sp_sum;
      wf3  <= (wp_sum == '0) ? SQW'(1) : wp_sum;
      tke3 <= tke2;
      omg3 <= omg2;
      rho3 <= rho2;
      nut3 <= nut2;
      vol3 <= vol2;
    end
  end

  // ---------------- ratio divider
  logic          vd;
  logic [QW-1:0] qd;
  logic [PW-1:0] payd;

  sst_rc_div #(.PW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .sf       (sf3),
    .wf       (wf3),
    .pay_in   ({sp3, vol3, nut3, rho3, omg3, tke3}),
    .out_valid(vd),
    .q        (qd),
    .pay_out  (payd)
  );

  logic [SW-1:0]  tke_d, omg_d, rho_d, nut_d, vol_d;
  logic [SQW-1:0] sp_d;
  assign tke_d = payd[31:0];
  assign omg_d = payd[63:32];
  assign rho_d = payd[95:64];
  assign nut_d = payd[127:96];
  assign vol_d = payd[159:128];
  assign sp_d  = payd[205:160];

  // ---------------- back stages 1..14
  logic [14:1] vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[13:1], vd};
    end
  end

  // B1 registers
  logic [63:0] rwp1;
  logic [54:0] pkl1, pkh1;
  logic [33:0] fp1;
  logic [SW-1:0] tke_b1, vol_b1;
  // B2 registers
  logic [47:0] brh2;
  logic [31:0] brl2;
  logic [56:0] pk_b2;
  logic [24:0] f_b2;
  logic [SW-1:0] tke_b2, vol_b2;
  // B3 registers
  logic [48:0] br3;
  logic [56:0] pk_b3;
  logic [24:0] f_b3;
  logic [SW-1:0] tke_b3, vol_b3;
  // B4 registers
  logic [55:0] dkl4, lhl4;
  logic [56:0] dkh4, lhh4;
  logic [56:0] pk_b4;
  logic [24:0] f_b4;
  logic [SW-1:0] vol_b4;
  // B5 registers
  logic [61:0] dk5;
  logic [47:0] lhs5;
  logic [56:0] pk_b5;
  logic [24:0] f_b5;
  logic [SW-1:0] vol_b5;
  // B6 registers
  logic [46:0] lml6, lmh6;
  logic [61:0] dk6;
  logic [47:0] lhs6;
  logic [56:0] pk_b6;
  logic [24:0] f_b6;
  logic [SW-1:0] vol_b6;
  // B7 registers
  logic [61:0] lim7, dk7;
  logic [47:0] lhs7;
  logic [56:0] pk_b7;
  logic [24:0] f_b7;
  logic [SW-1:0] vol_b7;
  // B8 registers
  logic [56:0] pk8;
  logic [61:0] dk8;
  logic [47:0] lhs8;
  logic [24:0] f_b8;
  logic [SW-1:0] vol_b8;
  // B9 registers
  logic [53:0] fl9;
  logic [52:0] fh9;
  logic [61:0] dk9;
  logic [47:0] lhs9;
  logic [SW-1:0] vol_b9;
  // B10 registers
  logic [57:0] fpk10;
  logic [61:0] dk10;
  logic [47:0] lhs10;
  logic [SW-1:0] vol_b10;
  // B11 registers
  logic        neg11;
  logic [61:0] dif11;
  logic [47:0] lhs11;
  logic [SW-1:0] vol_b11;
  // B12 registers
  logic        neg12;
  logic [62:0] ml12, mh12;
  logic [47:0] lhs12;
  // B13 registers
  logic        neg13;
  logic [77:0] mf13;
  logic [47:0] lhs13;
  // B14 output registers
  logic [47:0] rhs14, lhs14;

  // combinational pieces between back stages
  logic [33:0] fsub, fdif;
  logic [24:0] f_clamp;
  logic [77:0] pkp;
  logic [80:0] dkp, lhp;
  logic [64:0] dkf, lhf;
  logic [77:0] lmp;
  logic [69:0] lmf;
  logic [81:0] fpp;
  logic [93:0] mp;
  logic [47:0] mcap, mag;

  always_comb begin
    // rotation factor with clamp to 0..1.25
    fsub = {2'b0, cr1, 16'b0};
    fdif = fp1 - fsub;
    if (fp1 < fsub) begin
      f_clamp = '0;
    end else if (fdif > 34'(sst_rc_pkg::F_MAX)) begin
      f_clamp = sst_rc_pkg::F_MAX;
    end else begin
      f_clamp = fdif[24:0];
    end
    // production from split strain product
    pkp = {pkh1, 23'b0} + 78'(pkl1);
    // destruction and diagonal from split products
    dkp = {dkh4, 24'b0} + 81'(dkl4);
    lhp = {lhh4, 24'b0} + 81'(lhl4);
    dkf = dkp[80:16];
    lhf = lhp[80:16];
    // production limit
    lmp = {lmh6, 31'b0} + 78'(lml6);
    lmf = lmp[77:8];
    // corrected production
    fpp = {fh9, 29'b0} + 82'(fl9);
    // rhs magnitude
    mp   = {mh12, 31'b0} + 94'(ml12);
    mcap = neg13 ? sst_rc_pkg::NEG47 : sst_rc_pkg::POS47;
    mag  = (mf13 > 78'(mcap)) ? mcap : mf13[47:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // B1: first-level products
      rwp1   <= 64'(rho_d) * 64'(omg_d);
      pkl1   <= 55'(sp_d[22:0]) * 55'(nut_d);
      pkh1   <= 55'(sp_d[45:23]) * 55'(nut_d);
      fp1    <= (34'(cr1) + 34'd256) * 34'(qd);
      tke_b1 <= tke_d;
      vol_b1 <= vol_d;
      // B2: beta times rho*omega, production, rotation factor
      brh2   <= 48'(beta_star) * 48'(rwp1[63:32]);
      brl2   <= 32'(beta_star) * 32'(rwp1[31:16]);
      pk_b2  <= pkp[77:21];
      f_b2   <= f_clamp;
      tke_b2 <= tke_b1;
      vol_b2 <= vol_b1;
      // B3: combine beta product
      br3    <= 49'(brh2) + 49'(brl2[31:16]);
      pk_b3  <= pk_b2;
      f_b3   <= f_b2;
      tke_b3 <= tke_b2;
      vol_b3 <= vol_b2;
      // B4: destruction and diagonal partials
      dkl4   <= 56'(br3[23:0]) * 56'(tke_b3);
      dkh4   <= 57'(br3[48:24]) * 57'(tke_b3);
      lhl4   <= 56'(br3[23:0]) * 56'(vol_b3);
      lhh4   <= 57'(br3[48:24]) * 57'(vol_b3);
      pk_b4  <= pk_b3;
      f_b4   <= f_b3;
      vol_b4 <= vol_b3;
      // B5: saturate destruction and diagonal
      dk5    <= (dkf > 65'(sst_rc_pkg::LIM62)) ? sst_rc_pkg::LIM62 : dkf[61:0];
      lhs5   <= (lhf > 65'(sst_rc_pkg::MAX48U)) ? sst_rc_pkg::MAX48U : lhf[47:0];
      pk_b5  <= pk_b4;
      f_b5   <= f_b4;
      vol_b5 <= vol_b4;
      // B6: limit partials
      lml6   <= 47'(ratio) * 47'(dk5[30:0]);
      lmh6   <= 47'(ratio) * 47'(dk5[61:31]);
      dk6    <= dk5;
      lhs6   <= lhs5;
      pk_b6  <= pk_b5;
      f_b6   <= f_b5;
      vol_b6 <= vol_b5;
      // B7: saturate limit
      lim7   <= (lmf > 70'(sst_rc_pkg::LIM62)) ? sst_rc_pkg::LIM62 : lmf[61:0];
      dk7    <= dk6;
      lhs7   <= lhs6;
      pk_b7  <= pk_b6;
      f_b7   <= f_b6;
      vol_b7 <= vol_b6;
      // B8: clip production
      pk8    <= (62'(pk_b7) > lim7) ? lim7[56:0] : pk_b7;
      dk8    <= dk7;
      lhs8   <= lhs7;
      f_b8   <= f_b7;
      vol_b8 <= vol_b7;
      // B9: factor times production, split
      fl9    <= 54'(f_b8) * 54'(pk8[28:0]);
      fh9    <= 53'(f_b8) * 53'(pk8[56:29]);
      dk9    <= dk8;
      lhs9   <= lhs8;
      vol_b9 <= vol_b8;
      // B10: combine corrected production
      fpk10  <= fpp[81:24];
      dk10   <= dk9;
      lhs10  <= lhs9;
      vol_b10 <= vol_b9;
      // B11: signed difference as sign and magnitude
      neg11  <= (62'(fpk10) < dk10);
      dif11  <= (62'(fpk10) < dk10) ? (dk10 - 62'(fpk10)) : (62'(fpk10) - dk10);
      lhs11  <= lhs10;
      vol_b11 <= vol_b10;
      // B12: volume partials
      ml12   <= 63'(dif11[30:0]) * 63'(vol_b11);
      mh12   <= 63'(dif11[61:31]) * 63'(vol_b11);
      neg12  <= neg11;
      lhs12  <= lhs11;
      // B13: combine
      mf13   <= mp[93:16];
      neg13  <= neg12;
      lhs13  <= lhs12;
      // B14: saturate and apply sign
      rhs14  <= neg13 ? (48'd0 - mag) : mag;
      lhs14  <= lhs13;
    end
  end

  assign m_tvalid = vb[14];
  assign m_tdata  = {lhs14, rhs14};

endmodule

/* design/sst_rc_chk.sv */
// Port-level checker for the SST rotation-corrected TKE source block, bound to
// the top level. Depends on sst_rc_pkg for bus widths.
module sst_rc_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [sst_rc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result shown right after reset");

  // a stalled output stalls the input side
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  // an empty output stage never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind sst_tke_source_rotation_correction sst_rc_chk u_sst_rc_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

/* tb/sv/tb_sst_tke_source_rotation_correction.sv */
// Testbench for the SST rotation-corrected TKE source block: random and directed
// nodes on the input stream, results checked against an in-bench fixed-point predictor.
// Depends on sst_rc_pkg and the block's top level.
module tb_sst_tke_source_rotation_correction;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic [62:0] row_z;
    logic [62:0] row_y;
    logic [62:0] row_x;
    logic [31:0] vol;
    logic [31:0] nut;
    logic [31:0] rho;
    logic [31:0] omega;
    logic [31:0] tke;
  } node_t;

  typedef struct packed {
    logic [47:0] lhs;
    logic [47:0] rhs;
  } incr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [sst_rc_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [sst_rc_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = sst_rc_pkg::REG_BETA;
  logic [sst_rc_pkg::CFG_W-1:0] cfg_data = '0;

  // shadow registers
  logic [15:0] beta_q, ratio_q, cr1_q;
  logic [1:0] dims_q;

  node_t pending_nodes[$];
  incr_t expected_incr[$];
  int errors = 0;
  int checked = 0;
  int wdog = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit no_gaps = 1'b0;

  sst_tke_source_rotation_correction dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [127:0] clip(logic [127:0] v, logic [127:0] cap);
    return (v > cap) ? cap : v;
  endfunction

  function automatic logic signed [63:0] grad_at(logic [62:0] row, int j);
    logic [20:0] v;
    v = row[21*j +: 21];
    return 64'(signed'(v));
  endfunction

  // predict both increments for one node with the current register values
  function automatic incr_t predict_incr(node_t n);
    logic signed [63:0] g[3][3];
    logic signed [63:0] s, w;
    logic [127:0] sp, wp, pk, rw, br, dk, lim, fpk, mag, lhs, lim62, sf, wf, den, rem, q;
    logic signed [63:0] f;
    int d;
    incr_t r;
    logic [62:0] rows[3];
    rows[0] = n.row_x; rows[1] = n.row_y; rows[2] = n.row_z;
    lim62 = (128'd1 << 62) - 128'd1;
    d = (dims_q == sst_rc_pkg::DIMS_2D) ? 2 : 3;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) g[i][j] = grad_at(rows[i], j);
    sp = '0; wp = '0;
    for (int i = 0; i < d; i++)
      for (int j = 0; j < d; j++) begin
        s = g[i][j] + g[j][i];
        w = g[i][j] - g[j][i];
        sp += 128'(s * s);
        wp += 128'(w * w);
      end
    pk = clip((sp * n.nut) >> 21, lim62);
    rw = clip((128'(n.rho) * n.omega) >> 16, lim62);
    br = (beta_q * rw) >> 16;
    dk = clip((br * n.tke) >> 16, lim62);
    lim = clip((ratio_q * dk) >> 8, lim62);
    if (pk > lim) pk = lim;
    sf = (sp != '0) ? sp : 128'd1;
    wf = (wp != '0) ? wp : 128'd1;
    den = sf + wf;
    q = ((128'd2 * sf) << 16) / den;
    f = 64'((128'(256) + cr1_q) * q) - 64'(128'(cr1_q) << 16);
    if (f < 0) f = '0;
    if (f > 64'(sst_rc_pkg::F_MAX)) f = 64'(sst_rc_pkg::F_MAX);
    fpk = clip((128'(f) * pk) >> 24, lim62);
    if (fpk >= dk) begin
      mag = clip(((fpk - dk) * n.vol) >> 16, 128'(sst_rc_pkg::POS47));
      r.rhs = mag[47:0];
    end else begin
      mag = clip(((dk - fpk) * n.vol) >> 16, 128'(sst_rc_pkg::NEG47));
      r.rhs = 48'(-mag);
    end
    lhs = clip((br * n.vol) >> 16, 128'(sst_rc_pkg::MAX48U));
    r.lhs = lhs[47:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  // driver: push queued nodes, predicting at the transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_incr.push_back(predict_incr(node_t'(s_tdata[$bits(node_t)-1:0])));
        void'(pending_nodes.pop_front());
        send_gap = no_gaps ? 0 : $urandom_range(0, 19) * ($urandom_range(0, 3) == 0);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_nodes.size() > 0 && send_gap == 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= sst_rc_pkg::IN_TDATA_W'(pending_nodes[0]);
        end else begin
          s_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest expectation
  always @(posedge clk) begin
    incr_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = incr_t'(m_tdata);
        if (expected_incr.size() == 0) begin
          report_mismatch("unexpected result, rhs_increment", got.rhs, '0);
        end else begin
          want = expected_incr.pop_front();
          if (got.rhs !== want.rhs) report_mismatch("rhs_increment", got.rhs, want.rhs);
          if (got.lhs !== want.lhs) report_mismatch("lhs_increment", got.lhs, want.lhs);
          checked++;
        end
        recv_gap = no_gaps ? 0 : $urandom_range(0, 19) * ($urandom_range(0, 3) == 0);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) wdog <= 0;
    else if (pending_nodes.size() > 0 || expected_incr.size() > 0) wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Watchdog expired with %0d nodes pending", pending_nodes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [62:0] rand_row();
    return 63'({$urandom(), $urandom()});
  endfunction

  // in mode 1, small gradients with a wide scalar spread keep the outputs off saturation
  function automatic node_t rand_node(int mode);
    node_t n;
    n.tke = $urandom(); n.omega = $urandom(); n.rho = $urandom();
    n.nut = $urandom(); n.vol = $urandom();
    n.row_x = rand_row(); n.row_y = rand_row(); n.row_z = rand_row();
    if (mode == 1) begin
      n.tke >>= $urandom_range(0, 31); n.omega >>= $urandom_range(0, 31);
      n.rho >>= $urandom_range(0, 31); n.nut >>= $urandom_range(0, 31);
      n.vol >>= $urandom_range(0, 31);
      for (int j = 0; j < 3; j++) begin
        n.row_x[21*j +: 21] = 21'(signed'(10'($urandom())));
        n.row_y[21*j +: 21] = 21'(signed'(10'($urandom())));
        n.row_z[21*j +: 21] = 21'(signed'(10'($urandom())));
      end
    end
    return n;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      sst_rc_pkg::REG_BETA:  beta_q = val;
      sst_rc_pkg::REG_RATIO: ratio_q = val;
      sst_rc_pkg::REG_CR1:   cr1_q = val;
      sst_rc_pkg::REG_DIMS:  dims_q = val[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_nodes.size() == 0 && expected_incr.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    node_t n;
    beta_q = sst_rc_pkg::RST_BETA; ratio_q = sst_rc_pkg::RST_RATIO;
    cr1_q = sst_rc_pkg::RST_CR1; dims_q = sst_rc_pkg::RST_DIMS;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    no_gaps = 1'b1;
    // directed: all-zero, all-ones, pure strain, pure rotation, sign extremes
    n = '0; pending_nodes.push_back(n);
    n = '1; pending_nodes.push_back(n);
    n = '0; n.tke = 32'h10000; n.omega = 32'h10000; n.rho = 32'h10000;
    n.nut = 32'h10000; n.vol = 32'h10000;
    n.row_x[20:0] = 21'h400; pending_nodes.push_back(n);
    n.row_x = '0; n.row_x[41:21] = 21'h400; n.row_y[20:0] = 21'h1FFC00;
    pending_nodes.push_back(n);
    n.row_x = {3{21'h100000}}; n.row_y = {3{21'h0FFFFF}}; n.row_z = {3{21'h100000}};
    pending_nodes.push_back(n);
    n.nut = '1; n.vol = '1; pending_nodes.push_back(n);
    n.tke = '1; n.omega = '1; n.rho = '1; n.nut = '0; pending_nodes.push_back(n);
    for (int i = 0; i < 8; i++) pending_nodes.push_back(rand_node(i % 2));
    drain();
    no_gaps = 1'b0;
    // register settings: defaults, extremes, out-of-range dims codes, random
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: begin write_reg(sst_rc_pkg::REG_BETA, 16'hFFFF);
                 write_reg(sst_rc_pkg::REG_RATIO, 16'hFFFF);
                 write_reg(sst_rc_pkg::REG_CR1, 16'hFFFF);
                 write_reg(sst_rc_pkg::REG_DIMS, 16'(sst_rc_pkg::DIMS_2D)); end
        2: begin write_reg(sst_rc_pkg::REG_BETA, 16'd0);
                 write_reg(sst_rc_pkg::REG_RATIO, 16'd0);
                 write_reg(sst_rc_pkg::REG_CR1, 16'd0);
                 write_reg(sst_rc_pkg::REG_DIMS, 16'd0); end
        3: begin write_reg(sst_rc_pkg::REG_BETA, sst_rc_pkg::RST_BETA);
                 write_reg(sst_rc_pkg::REG_RATIO, sst_rc_pkg::RST_RATIO);
                 write_reg(sst_rc_pkg::REG_CR1, sst_rc_pkg::RST_CR1);
                 write_reg(sst_rc_pkg::REG_DIMS, 16'd1); end
        default: begin
          write_reg(sst_rc_pkg::REG_BETA, 16'($urandom()));
          write_reg(sst_rc_pkg::REG_RATIO, 16'($urandom()));
          write_reg(sst_rc_pkg::REG_CR1, 16'($urandom()));
          write_reg(sst_rc_pkg::REG_DIMS, 16'(2'($urandom())));
        end
      endcase
      no_gaps = (ph == 5);
      for (int i = 0; i < 200; i++) pending_nodes.push_back(rand_node($urandom_range(0, 3) != 0));
      drain();
    end
    $display("Checked %0d results over eight register settings, 2-D and 3-D,", checked);
    $display("with random stalls on both stream sides.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
